// ----- hw/rtl/lzss_inverted_literal_decoder_defines.svh -----
// ----------------------------------------------------------------------------
// lzss inverted literal decoder assertion macros
// Shared concurrent assertion forms for the decoder checker.
// ----------------------------------------------------------------------------
`ifndef LZSS_INVERTED_LITERAL_DECODER_DEFINES_SVH
`define LZSS_INVERTED_LITERAL_DECODER_DEFINES_SVH

// same-cycle implication, inactive while reset is asserted
`define LZSSILD_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, inactive while reset is asserted
`define LZSSILD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication that also covers the reset cycles
`define LZSSILD_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/lzssild_pkg.sv -----
// ----------------------------------------------------------------------------
// lzssild_pkg
// Shared constants, codes and control structs of the lzss decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lzssild_pkg;

    // window geometry
    localparam int WINDOW_DEPTH = 4096;
    localparam int WIN_AW       = $clog2(WINDOW_DEPTH);

    // field and counter widths
    localparam int DATA_W  = 8;
    localparam int CNT_W   = 24;
    localparam int SLOT_W  = 4;
    localparam int IDX_W   = 5;

    // stream format constants
    localparam logic [WIN_AW-1:0] WP_START       = WIN_AW'('hFEE);
    localparam logic [CNT_W-1:0]  LIMIT_RESET    = '1;
    localparam logic [SLOT_W-1:0] SLOTS_PER_FLAG = SLOT_W'(8);
    localparam int                MIN_MATCH      = 3;

    // meaning of the next compressed byte
    typedef logic [1:0] kind_t;
    localparam kind_t KIND_FLAG  = 2'd0;
    localparam kind_t KIND_LIT   = 2'd1;
    localparam kind_t KIND_PAIR1 = 2'd2;
    localparam kind_t KIND_PAIR2 = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic take;     // input transaction accepted this cycle
        logic emit;     // commit one byte to output and window
        logic sel_lit;  // emitted byte is the inverted literal
        logic clear;    // return parse state and fill count to reset
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        kind_t kind;       // role of the byte on s_tdata
        logic  room;       // output limit not yet reached
        logic  slot_free;  // output register can take a byte
        logic  copy_last;  // current copy byte is the final one
        logic  last_item;  // current item was marked last
    } dp_status_t;

endpackage

// ----- hw/rtl/lzssild_ram.sv -----
// ----------------------------------------------------------------------------
// lzssild_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lzssild_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/lzssild_dp.sv -----
// ----------------------------------------------------------------------------
// lzssild_dp
// Datapath: parse state, history window, fill count and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lzssild_dp (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [lzssild_pkg::CNT_W-1:0]   cfg_wdata,
    input  logic [lzssild_pkg::DATA_W-1:0]  s_tdata,
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [lzssild_pkg::DATA_W-1:0]  m_tdata,
    output logic                            m_tlast,
    input  lzssild_pkg::dp_cmd_t            cmd,
    output lzssild_pkg::dp_status_t         status
);
    import lzssild_pkg::*;

    // configuration
    logic [CNT_W-1:0]  max_len_reg;

    // parse state
    logic [DATA_W-1:0] flags_reg, flags_next;
    logic [SLOT_W-1:0] slots_reg, slots_next;
    logic [DATA_W-1:0] pend_low_reg, pend_low_next;
    logic              awaiting_reg, awaiting_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [WIN_AW-1:0] wp_reg, wp_next;

    // per-item working registers
    logic [WIN_AW-1:0] base_reg;
    logic [IDX_W-1:0]  len_m1_reg;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [DATA_W-1:0] lit_reg;
    logic              last_reg;

    // read return tracking
    logic              hit_reg;
    logic [DATA_W-1:0] hit_data_reg;
    logic              valid_reg;

    // output register
    logic              m_valid_reg;
    logic [DATA_W-1:0] m_data_reg;
    logic              m_last_reg;

    logic [WIN_AW-1:0] rd_addr;
    logic [WIN_AW-1:0] fill_dist;
    logic              rd_valid;
    logic              rd_hit;
    logic [DATA_W-1:0] ram_q;
    logic [DATA_W-1:0] copy_byte;
    logic [DATA_W-1:0] emit_byte;
    logic              emit_last;
    logic [CNT_W-1:0]  count_inc;
    logic [IDX_W-1:0]  idx_inc;
    kind_t             kind;

    // role of the incoming byte
    always_comb begin
        if (slots_reg == '0) begin
            kind = KIND_FLAG;
        end else if (awaiting_reg) begin
            kind = KIND_PAIR2;
        end else if (flags_reg[0]) begin
            kind = KIND_LIT;
        end else begin
            kind = KIND_PAIR1;
        end
    end

    assign count_inc = count_reg + CNT_W'(1);
    assign idx_inc   = idx_reg + IDX_W'(1);

    // window read address: pair start on accept, else next copy byte
    always_comb begin
        if (cmd.take) begin
            rd_addr = {s_tdata[DATA_W-1:DATA_W-4], pend_low_reg};
        end else begin
            rd_addr = base_reg + WIN_AW'(cmd.emit ? idx_inc : idx_reg);
        end
    end

    // entries not written since the last clear read as zero
    assign fill_dist = rd_addr - WP_START;
    assign rd_valid  = (count_reg[CNT_W-1:WIN_AW] != '0) ||
                       (fill_dist < count_reg[WIN_AW-1:0]);
    // read of the entry being written this cycle takes the new byte
    assign rd_hit    = cmd.emit && (rd_addr == wp_reg);

    lzssild_ram #(
        .WIDTH (DATA_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_window (
        .aclk  (aclk),
        .we    (cmd.emit),
        .waddr (wp_reg),
        .wdata (emit_byte),
        .raddr (rd_addr),
        .rdata (ram_q)
    );

    // byte to emit
    assign copy_byte = hit_reg ? hit_data_reg : (valid_reg ? ram_q : '0);
    assign emit_byte = cmd.sel_lit ? ~lit_reg : copy_byte;
    assign emit_last = cmd.sel_lit || (idx_reg == len_m1_reg) || (count_inc == max_len_reg);

    // parse state and fill count
    always_comb begin
        flags_next    = flags_reg;
        slots_next    = slots_reg;
        pend_low_next = pend_low_reg;
        awaiting_next = awaiting_reg;
        count_next    = count_reg;
        wp_next       = wp_reg;
        idx_next      = idx_reg;
        if (cmd.take) begin
            idx_next = '0;
            case (kind)
                KIND_FLAG: begin
                    flags_next = s_tdata;
                    slots_next = SLOTS_PER_FLAG;
                end
                KIND_PAIR1: begin
                    pend_low_next = s_tdata;
                    awaiting_next = 1'b1;
                end
                default: begin
                    awaiting_next = 1'b0;
                    flags_next    = flags_reg >> 1;
                    slots_next    = slots_reg - SLOT_W'(1);
                end
            endcase
        end
        if (cmd.emit) begin
            count_next = count_inc;
            wp_next    = wp_reg + WIN_AW'(1);
            idx_next   = idx_inc;
        end
        if (cmd.clear) begin
            flags_next    = '0;
            slots_next    = '0;
            pend_low_next = '0;
            awaiting_next = 1'b0;
            count_next    = '0;
            wp_next       = WP_START;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg  <= LIMIT_RESET;
            flags_reg    <= '0;
            slots_reg    <= '0;
            pend_low_reg <= '0;
            awaiting_reg <= 1'b0;
            count_reg    <= '0;
            wp_reg       <= WP_START;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                max_len_reg <= cfg_wdata;
            end
            flags_reg    <= flags_next;
            slots_reg    <= slots_next;
            pend_low_reg <= pend_low_next;
            awaiting_reg <= awaiting_next;
            count_reg    <= count_next;
            wp_reg       <= wp_next;
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        idx_reg      <= idx_next;
        hit_reg      <= rd_hit;
        hit_data_reg <= emit_byte;
        valid_reg    <= rd_valid;
        if (cmd.take) begin
            base_reg   <= {s_tdata[DATA_W-1:DATA_W-4], pend_low_reg};
            len_m1_reg <= IDX_W'(s_tdata[3:0]) + IDX_W'(MIN_MATCH - 1);
            lit_reg    <= s_tdata;
            last_reg   <= s_tlast;
        end
        if (cmd.emit) begin
            m_data_reg <= emit_byte;
            m_last_reg <= emit_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    assign status.kind      = kind;
    assign status.room      = count_reg < max_len_reg;
    assign status.slot_free = !m_valid_reg || m_tready;
    assign status.copy_last = idx_reg == len_m1_reg;
    assign status.last_item = last_reg;

endmodule

// ----- hw/rtl/lzssild_ctrl.sv -----
// ----------------------------------------------------------------------------
// lzssild_ctrl
// Controller: accepts compressed bytes and sequences literal and copy output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lzssild_ctrl (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic                     s_tlast,
    input  lzssild_pkg::dp_status_t  status,
    output lzssild_pkg::dp_cmd_t     cmd
);
    import lzssild_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LIT  = 2'd1;
    localparam logic [1:0] S_COPY = 2'd2;

    logic [1:0] state_reg, state_next;

    // next state and datapath commands
    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        s_tready    = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.take = 1'b1;
                    unique case (status.kind) inside
                        KIND_LIT:              state_next = S_LIT;
                        KIND_PAIR2:            state_next = S_COPY;
                        KIND_FLAG, KIND_PAIR1: cmd.clear  = s_tlast;
                    endcase
                end
            end
            S_LIT: begin
                cmd.sel_lit = 1'b1;
                if (!status.room) begin
                    cmd.clear  = status.last_item;
                    state_next = S_IDLE;
                end else if (status.slot_free) begin
                    cmd.emit   = 1'b1;
                    cmd.clear  = status.last_item;
                    state_next = S_IDLE;
                end
            end
            S_COPY: begin
                if (!status.room) begin
                    cmd.clear  = status.last_item;
                    state_next = S_IDLE;
                end else if (status.slot_free) begin
                    cmd.emit = 1'b1;
                    if (status.copy_last) begin
                        cmd.clear  = status.last_item;
                        state_next = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- hw/rtl/lzss_inverted_literal_decoder.sv -----
// A taken literal is held in lit_reg until S_LIT emits it to m_tdata.
// Flag and first pair bytes need only S_IDLE; a literal also passes S_LIT, a
// pair's second byte S_COPY (3 to 18 copy bytes), one window byte per cycle
// while the output register is free, via the single read port of the history RAM.
// Reset: aresetn low for one cycle clears state; the window needs no clearing
// pass, entries beyond the fill count read as zero.
// ----------------------------------------------------------------------------
// lzss_inverted_literal_decoder
// LZSS decoder with 4 KB window and inverted literals, stream in and out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lzss_inverted_literal_decoder (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [lzssild_pkg::CNT_W-1:0]   cfg_wdata,   // max_output_len
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [lzssild_pkg::DATA_W-1:0]  s_tdata,     // [7:0] in_byte
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [lzssild_pkg::DATA_W-1:0]  m_tdata,     // [7:0] out_byte
    output logic                            m_tlast
);
    import lzssild_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // sequencing
    lzssild_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tlast  (s_tlast),
        .status   (status),
        .cmd      (cmd)
    );

    // window, parse state and output register
    lzssild_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

// ----- hw/rtl/lzssild_checker.sv -----
// ----------------------------------------------------------------------------
// lzssild_checker
// Port-level assertions for the decoder, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "lzss_inverted_literal_decoder_defines.svh"

module lzssild_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [lzssild_pkg::DATA_W-1:0]  m_tdata,
    input logic                            m_tlast
);

    // a stalled output transaction holds its payload
    `LZSSILD_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "output changed while stalled")

    // bytes are produced only while input is held off
    `LZSSILD_ASSERT_SAME(a_emit_busy, aclk, aresetn, $rose(m_tvalid), !$past(s_tready), "output produced while input was open")

    // reset empties the output register
    `LZSSILD_ASSERT_NEXT_ALWAYS(a_reset_empty, aclk, !aresetn, !m_tvalid, "output valid after reset")

endmodule

bind lzss_inverted_literal_decoder lzssild_checker u_checker (.*);

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the lzss inverted literal decoder against a cycle-free software decode.
// Compressed bytes go in through the slave stream. Decoded bytes come out
// through the master stream. Both sides idle at random. Every output
// transaction is compared with the oldest byte that the decode predicts.
// ----------------------------------------------------------------------------

module tb;

    import lzssild_pkg::*;

    // software decode of the compressed stream, plus the bytes still owed
    class decode_tracker;
        logic [DATA_W-1:0] history [WINDOW_DEPTH];
        logic [WIN_AW-1:0] wr_pos;
        logic [7:0]        slot_bits;
        logic [SLOT_W-1:0] slots_left;
        logic [7:0]        offset_lo;
        logic              in_pair;
        logic [CNT_W-1:0]  out_count;
        logic [CNT_W-1:0]  out_limit;
        logic [8:0]        pending_out [$];   // {run_end, out_byte}
        int                errors;

        function new();
            out_limit = LIMIT_RESET;
            errors    = 0;
            restart();
        endfunction

        function void restart();
            foreach (history[i]) history[i] = '0;
            wr_pos     = WP_START;
            slot_bits  = '0;
            slots_left = '0;
            offset_lo  = '0;
            in_pair    = 1'b0;
            out_count  = '0;
        endfunction

        // role of the next compressed byte
        function kind_t next_kind();
            if (slots_left == 0) return KIND_FLAG;
            if (in_pair) return KIND_PAIR2;
            if (slot_bits[0]) return KIND_LIT;
            return KIND_PAIR1;
        endfunction

        // emit one byte into the window unless the output limit is reached
        function bit commit(logic [DATA_W-1:0] d);
            if (out_count >= out_limit) return 1'b0;
            history[wr_pos] = d;
            wr_pos    = wr_pos + 1'b1;
            out_count = out_count + 1'b1;
            return 1'b1;
        endfunction

        function void use_slot();
            slot_bits = slot_bits >> 1;
            if (slots_left != 0) slots_left = slots_left - 1'b1;
        endfunction

        // decode one accepted input transaction
        function void take_compressed(logic [DATA_W-1:0] b, logic last);
            logic [WIN_AW-1:0] src;
            logic [DATA_W-1:0] d;
            logic [DATA_W-1:0] got [$];
            int                len;
            case (next_kind())
                KIND_FLAG: begin
                    slot_bits  = b;
                    slots_left = SLOTS_PER_FLAG;
                end
                KIND_PAIR2: begin
                    src = {b[7:4], offset_lo};
                    len = int'(b[3:0]) + MIN_MATCH;
                    for (int i = 0; i < len; i++) begin
                        d = history[src];
                        if (commit(d)) got.push_back(d);
                        src = src + 1'b1;
                    end
                    in_pair = 1'b0;
                    use_slot();
                end
                KIND_LIT: begin
                    if (commit(~b)) got.push_back(~b);
                    use_slot();
                end
                default: begin
                    offset_lo = b;
                    in_pair   = 1'b1;
                end
            endcase
            foreach (got[i]) pending_out.push_back({i == got.size() - 1, got[i]});
            if (last) restart();
        endfunction

        task report_mismatch(string what);
            $display("tb: mismatch at %0t: %s", $time, what);
            errors++;
        endtask

        // compare one output transaction with the oldest owed byte
        task match_output(logic [DATA_W-1:0] b, logic last);
            logic [8:0] want;
            if (pending_out.size() == 0) begin
                report_mismatch($sformatf("unexpected byte %h last %b", b, last));
                return;
            end
            want = pending_out.pop_front();
            if (b !== want[7:0])
                report_mismatch($sformatf("out_byte %h, want %h", b, want[7:0]));
            if (last !== want[8])
                report_mismatch($sformatf("run_end %b, want %b", last, want[8]));
        endtask
    endclass

    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               cfg_we    = 1'b0;
    logic [CNT_W-1:0]   cfg_wdata = '0;
    logic               s_tvalid  = 1'b0;
    logic               s_tready;
    logic [DATA_W-1:0]  s_tdata   = '0;   // [7:0] in_byte
    logic               s_tlast   = 1'b0;
    logic               m_tvalid;
    logic               m_tready  = 1'b0;
    logic [DATA_W-1:0]  m_tdata;          // [7:0] out_byte
    logic               m_tlast;

    decode_tracker sb = new();
    int            n_sent     = 0;
    bit            src_quiet  = 1'b0;
    bit            sink_quiet = 1'b0;
    logic [3:0]    next_hi    = '0;

    always #2 aclk = ~aclk;

    lzss_inverted_literal_decoder i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // one input transaction, entered and left at a falling edge
    task automatic send_item(logic [DATA_W-1:0] b, logic last);
        int gap;
        gap = src_quiet ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        sb.take_compressed(b, last);
        n_sent++;
        @(negedge aclk);
    endtask

    // well-formed compressed bytes that follow the decoder's parse state
    task automatic send_stream(int budget, bit end_last);
        logic [DATA_W-1:0] b;
        logic [WIN_AW-1:0] src;
        int                r;
        while (budget > 0) begin
            case (sb.next_kind())
                KIND_FLAG: begin
                    r = $urandom_range(0, 9);
                    b = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom);
                end
                KIND_LIT: b = 8'($urandom);
                KIND_PAIR1: begin
                    // mostly copy from recent output, sometimes anywhere
                    if ($urandom_range(0, 4) == 0)
                        src = WIN_AW'($urandom);
                    else
                        src = sb.wr_pos - WIN_AW'($urandom_range(1, 48));
                    next_hi = src[11:8];
                    b       = src[7:0];
                end
                default: begin
                    if ($urandom_range(0, 3) == 0)
                        b = {next_hi, 4'($urandom)};
                    else
                        b = {next_hi, 4'($urandom_range(0, 5))};
                end
            endcase
            send_item(b, end_last && budget == 1);
            budget--;
        end
    endtask

    task automatic send_noise(int n);
        repeat (n) send_item(8'($urandom), $urandom_range(0, 3) == 0);
    endtask

    task automatic random_traffic(int goal);
        int target;
        int remaining;
        int chunk;
        target = n_sent + goal;
        while (n_sent < target) begin
            remaining = target - n_sent;
            src_quiet = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 9) < 8) begin
                chunk = $urandom_range(4, 36);
                if (chunk > remaining) chunk = remaining;
                send_stream(chunk, $urandom_range(0, 9) != 0);
            end else begin
                chunk = $urandom_range(1, 6);
                if (chunk > remaining) chunk = remaining;
                send_noise(chunk);
            end
        end
    endtask

    // register write once the decoder has drained
    task automatic write_limit(logic [CNT_W-1:0] v);
        s_tvalid <= 1'b0;
        while (sb.pending_out.size() != 0) @(negedge aclk);
        repeat (24) @(negedge aclk);
        cfg_wdata <= v;
        cfg_we    <= 1'b1;
        @(posedge aclk);
        sb.out_limit = v;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // result side: random stalls, check on every output transaction
    initial begin
        int hold;
        hold = 0;
        forever begin
            @(negedge aclk);
            if (hold > 0) begin
                m_tready <= 1'b0;
                hold--;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 299) == 0) sink_quiet = !sink_quiet;
                if (!sink_quiet) hold = pick_gap();
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.match_output(m_tdata, m_tlast);
    end

    // stimulus
    initial begin
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        write_limit(LIMIT_RESET);

        // a flag byte, then four literals: the byte extremes and two mixed patterns
        send_item(8'h0F, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'hA5, 1'b0);
        send_item(8'h5A, 1'b0);
        // copy the first three literals back
        send_item(8'hEE, 1'b0);
        send_item(8'hF0, 1'b0);
        // longest copy, overlapping its own output and wrapping the window
        send_item(8'hF1, 1'b0);
        send_item(8'hFF, 1'b0);
        // offset zero, longest length
        send_item(8'h00, 1'b0);
        send_item(8'h0F, 1'b0);
        // pair cut off after its first byte
        send_item(8'h34, 1'b1);
        // flag byte alone ends the stream
        send_item(8'hFF, 1'b1);
        // a single literal ends the stream
        send_item(8'h01, 1'b0);
        send_item(8'h3C, 1'b1);
        // window reads back cleared, then a pair marked last
        send_item(8'h00, 1'b0);
        send_item(8'hEE, 1'b0);
        send_item(8'hF0, 1'b0);
        send_item(8'h23, 1'b0);
        send_item(8'h12, 1'b1);

        random_traffic(130);

        write_limit(CNT_W'($urandom_range(1, 40)));
        random_traffic(100);

        // limit hit mid-stream, then raised so emission resumes
        send_item(8'($urandom), 1'b1);
        write_limit(CNT_W'(8));
        send_stream(30, 1'b0);
        write_limit(LIMIT_RESET);
        send_stream(30, 1'b1);

        write_limit('0);
        random_traffic(40);
        write_limit(CNT_W'(1));
        random_traffic(20);
        write_limit(LIMIT_RESET);
        random_traffic(90);

        s_tvalid <= 1'b0;
        while (sb.pending_out.size() != 0) @(negedge aclk);
        repeat (30) @(negedge aclk);
        while (sb.pending_out.size() != 0) begin
            sb.report_mismatch($sformatf("byte %h never came", sb.pending_out[0][7:0]));
            void'(sb.pending_out.pop_front());
        end
        if (sb.errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

    // watchdog
    initial begin
        #10_000_000;
        $display("tb: errors");
        $finish;
    end

endmodule
